// ===== hw/rtl/deq_pkg.sv =====
// Shared constants and types for the double-ended queue.
// Operation and status codes, field widths, controller/datapath structs.
// No dependencies.
package deq_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Beat field widths
    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_PUSH_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture request beat
        logic exec;   // update pointers, access ring memory
        logic emit;   // load response register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_free;   // response register empty or draining
    } t_ctrl_sts;

endpackage

// ===== hw/rtl/deq_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on deq_pkg for field widths.
interface deq_req_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::OP_W-1:0]      operation;
    logic [deq_pkg::VALUE_W-1:0]   write_value;
    logic [deq_pkg::POS_W-1:0]     position;

    modport source (output valid, operation, write_value, position, input ready);
    modport sink   (input valid, operation, write_value, position, output ready);
endinterface

interface deq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::VALUE_W-1:0]   read_value;
    logic [deq_pkg::COUNT_W-1:0]   element_count;
    logic                          is_empty;
    logic                          is_full;
    logic [deq_pkg::STAT_W-1:0]    status;

    modport source (output valid, read_value, element_count, is_empty, is_full, status,
                    input ready);
    modport sink   (input valid, read_value, element_count, is_empty, is_full, status,
                    output ready);
endinterface

// ===== hw/rtl/deq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/deq_ctrl.sv =====
// Sequencer for the double-ended queue: accept, execute, respond.
// Depends on deq_pkg for the command and status structs.
module deq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  deq_pkg::t_ctrl_sts i_sts,
    output deq_pkg::t_ctrl_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESP;
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ===== hw/rtl/deq_dp.sv =====
// Datapath: request capture, head/count pointers, ring memory, response register.
// Depends on deq_pkg and deq_ram.
module deq_dp #(
    parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  deq_pkg::t_ctrl_cmd           i_cmd,
    output deq_pkg::t_ctrl_sts           o_sts,
    input  logic [deq_pkg::OP_W-1:0]     i_operation,
    input  logic [deq_pkg::VALUE_W-1:0]  i_write_value,
    input  logic [deq_pkg::POS_W-1:0]    i_position,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [deq_pkg::VALUE_W-1:0]  o_read_value,
    output logic [deq_pkg::COUNT_W-1:0]  o_element_count,
    output logic                         o_is_empty,
    output logic                         o_is_full,
    output logic [deq_pkg::STAT_W-1:0]   o_status
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (DATA_WIDTH > deq_pkg::VALUE_W) ? DATA_WIDTH : deq_pkg::VALUE_W;
    localparam int PW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;
    localparam int OW = (CW > deq_pkg::COUNT_W) ? CW : deq_pkg::COUNT_W;
    localparam logic [CW:0]   CAP_SUM  = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT  = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    // Captured request
    logic [deq_pkg::OP_W-1:0]  r_op;
    logic [DATA_WIDTH-1:0]     r_wval;
    logic [deq_pkg::POS_W-1:0] r_pos;

    // Queue state
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_head;
    logic [CW-1:0] n_count;

    // Pending result
    logic                        r_use_rd;
    logic [deq_pkg::STAT_W-1:0]  r_stat;

    // Response register
    logic                          r_out_valid;
    logic [deq_pkg::VALUE_W-1:0]   r_out_value;
    logic [deq_pkg::COUNT_W-1:0]   r_out_count;
    logic                          r_out_empty;
    logic                          r_out_full;
    logic [deq_pkg::STAT_W-1:0]    r_out_stat;

    // Execute-stage logic
    logic                       full;
    logic                       empty;
    logic                       bad_index;
    logic [CW-1:0]              offset;
    logic [CW:0]                slot_sum;
    logic [CW:0]                slot_wrap;
    logic [AW-1:0]              slot;
    logic [AW-1:0]              head_inc;
    logic [AW-1:0]              head_dec;
    logic                       we;
    logic                       re;
    logic                       use_rd;
    logic [deq_pkg::STAT_W-1:0] stat;
    logic [DATA_WIDTH-1:0]      rdata;
    logic [XW-1:0]              wval_ext;
    logic [XW-1:0]              rdata_ext;
    logic [OW-1:0]              count_ext;
    logic [PW-1:0]              pos_ext;
    logic [PW-1:0]              cnt_pos_ext;

    assign full        = (r_count == CAP_CNT);
    assign empty       = (r_count == '0);
    assign pos_ext     = PW'(r_pos);
    assign cnt_pos_ext = PW'(r_count);
    assign bad_index   = (pos_ext >= cnt_pos_ext);
    assign head_inc    = (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
    assign head_dec    = (r_head == '0) ? LAST_SLOT : r_head - AW'(1);

    // Ring slot of element at offset from the front
    assign slot_sum  = (CW + 1)'(r_head) + (CW + 1)'(offset);
    assign slot_wrap = (slot_sum >= CAP_SUM) ? slot_sum - CAP_SUM : slot_sum;
    assign slot      = slot_wrap[AW-1:0];

    // Operation decode
    always_comb begin
        offset  = '0;
        n_head  = r_head;
        n_count = r_count;
        we      = 1'b0;
        re      = 1'b0;
        use_rd  = 1'b0;
        stat    = deq_pkg::ST_OK;
        unique case (r_op)
            deq_pkg::OP_PUSH_BACK: begin
                offset = r_count;
                if (full) begin
                    stat = deq_pkg::ST_PUSH_FULL;
                end else begin
                    we      = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    stat = deq_pkg::ST_PUSH_FULL;
                end else begin
                    we      = 1'b1;
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::OP_POP_BACK: begin
                offset = r_count - CW'(1);
                if (empty) begin
                    stat = deq_pkg::ST_POP_EMPTY;
                end else begin
                    re      = 1'b1;
                    use_rd  = 1'b1;
                    n_count = r_count - CW'(1);
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    stat = deq_pkg::ST_POP_EMPTY;
                end else begin
                    re      = 1'b1;
                    use_rd  = 1'b1;
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                end
            end
            deq_pkg::OP_READ_AT: begin
                offset = CW'(r_pos);
                if (bad_index) begin
                    stat = deq_pkg::ST_BAD_INDEX;
                end else begin
                    re     = 1'b1;
                    use_rd = 1'b1;
                end
            end
            deq_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Ring memory; push front writes the new head slot
    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && we),
        .i_waddr ((r_op == deq_pkg::OP_PUSH_FRONT) ? head_dec : slot),
        .i_wdata (r_wval),
        .i_re    (i_cmd.exec && re),
        .i_raddr (slot),
        .o_rdata (rdata)
    );

    assign wval_ext  = XW'(i_write_value);
    assign rdata_ext = XW'(rdata);
    assign count_ext = OW'(r_count);

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_wval <= wval_ext[DATA_WIDTH-1:0];
            r_pos  <= i_position;
        end
        if (i_cmd.exec) begin
            r_use_rd <= use_rd;
            r_stat   <= stat;
        end
    end

    // Head and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_value <= r_use_rd ? rdata_ext[deq_pkg::VALUE_W-1:0] : '0;
            r_out_count <= count_ext[deq_pkg::COUNT_W-1:0];
            r_out_empty <= empty;
            r_out_full  <= full;
            r_out_stat  <= r_stat;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_read_value    = r_out_value;
    assign o_element_count = r_out_count;
    assign o_is_empty      = r_out_empty;
    assign o_is_full       = r_out_full;
    assign o_status        = r_out_stat;
endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Double-ended queue in a ring memory, top level.
// Depends on deq_pkg, deq_if, deq_ctrl, deq_dp (which holds deq_ram).
//
// Usage:
//   Requests arrive on i_req (valid/ready). Each beat carries an operation
//   (push back/front, pop back/front, read at index, clear), a write value
//   and a position. Every request yields exactly one response beat on o_rsp
//   with the value read or removed, the element count afterwards, empty and
//   full flags and a status (ok, pop on empty, push on full, bad index).
//   Each request is captured, then the pointers update and the ring memory
//   is accessed, then the registered memory read lands in the response
//   register; a new request is accepted only once the last one is emitted.
//   Reset (i_rst_n low, synchronous) empties the queue and drops any pending
//   response; ring memory contents are not cleared and need no sweep.
//   When the receiver stalls, the response is held in the output register;
//   one further request is accepted and executed, then waits until that
//   register frees before the queue accepts again.
module double_ended_queue #(
    parameter int CAPACITY   = deq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_req_if.sink    i_req,
    deq_rsp_if.source  o_rsp
);
    deq_pkg::t_ctrl_cmd cmd;
    deq_pkg::t_ctrl_sts sts;
    logic               in_ready;

    // Sequencer
    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    assign i_req.ready = in_ready;

    // Pointers, ring memory, response register
    deq_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_req.operation),
        .i_write_value   (i_req.write_value),
        .i_position      (i_req.position),
        .o_valid         (o_rsp.valid),
        .i_ready         (o_rsp.ready),
        .o_read_value    (o_rsp.read_value),
        .o_element_count (o_rsp.element_count),
        .o_is_empty      (o_rsp.is_empty),
        .o_is_full       (o_rsp.is_full),
        .o_status        (o_rsp.status)
    );
endmodule
